FILE: rtl/ssc_pkg.sv
`default_nettype none
package ssc_pkg;

	localparam int CW    = 32;
	localparam int FB    = 16;
	localparam int TW    = 16;
	localparam int DSTW  = 48;
	localparam int DW    = CW + 1;
	localparam int PW    = 2 * DW;
	localparam int DOTW  = PW + 2;
	localparam int HW    = DOTW / 2;
	localparam int DIV_W = 2 * DOTW + 2;
	localparam int BSW   = DOTW + FB + 2;
	localparam int MW    = DW + FB + 2;
	localparam int PTW   = CW + 2;
	localparam int DFW   = CW + 3;
	localparam int SQW   = 2 * DFW;
	localparam int SUMW  = SQW + 2;

	typedef logic signed [CW-1:0]    coord_t;
	typedef logic signed [DW-1:0]    diff_t;
	typedef logic signed [DOTW-1:0]  dot_t;
	typedef logic signed [DIV_W-1:0] wide_t;
	typedef logic [FB:0]             frac_t;
	typedef coord_t [11:0]           pts_t;

	typedef struct packed {
		coord_t [2:0] p1;
		coord_t [2:0] p2;
		diff_t [2:0]  d1;
		diff_t [2:0]  d2;
		diff_t [2:0]  r;
		dot_t         a;
		dot_t         e;
		dot_t         b;
		dot_t         c;
		dot_t         f;
		logic         adeg;
		logic         edeg;
		logic         sel_s;
		frac_t        s;
		frac_t        t;
	} ctx_t;

	typedef struct packed {
		logic [DSTW-1:0] sq_dist;
		frac_t           s;
		frac_t           t;
		coord_t [2:0]    n1;
		coord_t [2:0]    n2;
	} res_t;

	function automatic diff_t sx_d(input logic [CW-1:0] v);
		return {v[CW-1], v};
	endfunction

	function automatic wide_t sx_w(input dot_t v);
		return DIV_W'(v);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ssc_if.sv
`default_nettype none
interface ssc_req_if import ssc_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t first_start_x;
	coord_t first_start_y;
	coord_t first_start_z;
	coord_t first_end_x;
	coord_t first_end_y;
	coord_t first_end_z;
	coord_t second_start_x;
	coord_t second_start_y;
	coord_t second_start_z;
	coord_t second_end_x;
	coord_t second_end_y;
	coord_t second_end_z;
	modport source (output valid, first_start_x, first_start_y, first_start_z,
		first_end_x, first_end_y, first_end_z, second_start_x, second_start_y,
		second_start_z, second_end_x, second_end_y, second_end_z, input ready);
	modport sink (input valid, first_start_x, first_start_y, first_start_z,
		first_end_x, first_end_y, first_end_z, second_start_x, second_start_y,
		second_start_z, second_end_x, second_end_y, second_end_z, output ready);
endinterface

interface ssc_rsp_if import ssc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [DSTW-1:0] squared_distance;
	frac_t           param_first;
	frac_t           param_second;
	coord_t          near_first_x;
	coord_t          near_first_y;
	coord_t          near_first_z;
	coord_t          near_second_x;
	coord_t          near_second_y;
	coord_t          near_second_z;
	modport source (output valid, squared_distance, param_first, param_second,
		near_first_x, near_first_y, near_first_z, near_second_x, near_second_y,
		near_second_z, input ready);
	modport sink (input valid, squared_distance, param_first, param_second,
		near_first_x, near_first_y, near_first_z, near_second_x, near_second_y,
		near_second_z, output ready);
endinterface

interface ssc_cfg_if import ssc_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [TW-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/ssc_div.sv
`default_nettype none
module ssc_div import ssc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  valid_i,
	input  wire wide_t num_i,
	input  wire wide_t den_i,
	input  wire ctx_t  ctx_i,
	output logic       valid_o,
	output frac_t      quot_o,
	output ctx_t       ctx_o
);
	logic [DIV_W-1:0] rem_s [0:FB];
	logic [DIV_W-1:0] den_s [0:FB];
	logic [FB-1:0]    q_s   [0:FB];
	logic             zero_s [0:FB];
	logic             one_s  [0:FB];
	logic             vld_s  [0:FB];
	ctx_t             ctx_s  [0:FB];

	// clamp flags and first remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= num_i;
			den_s[0]  <= den_i;
			q_s[0]    <= '0;
			zero_s[0] <= (num_i <= 0);
			one_s[0]  <= (num_i >= den_i);
			ctx_s[0]  <= ctx_i;
		end
	end

	// one quotient bit a stage
	for (genvar k = 1; k <= FB; k++) begin : g_step
		logic [DIV_W:0] tr;
		logic           ge;
		assign tr = {rem_s[k-1], 1'b0};
		assign ge = (tr >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DIV_W'(tr - {1'b0, den_s[k-1]}) : tr[DIV_W-1:0];
				den_s[k]  <= den_s[k-1];
				q_s[k]    <= {q_s[k-1][FB-2:0], ge};
				zero_s[k] <= zero_s[k-1];
				one_s[k]  <= one_s[k-1];
				ctx_s[k]  <= ctx_s[k-1];
			end
		end
	end

	assign valid_o = vld_s[FB];
	assign ctx_o   = ctx_s[FB];
	assign quot_o  = zero_s[FB] ? '0 :
		one_s[FB] ? frac_t'(1 << FB) : {1'b0, q_s[FB]};

endmodule
`default_nettype wire

FILE: rtl/ssc_setup.sv
`default_nettype none
module ssc_setup import ssc_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [TW-1:0] thr,
	input  wire logic          valid_i,
	input  wire pts_t          pts_i,
	output logic               valid_o,
	output wide_t              num_o,
	output wide_t              den_o,
	output ctx_t               ctx_o
);
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	ctx_t  ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	ctx_t  ctx_d1, ctx_d3, ctx_d4;
	logic signed [PW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pe_s2 [3];
	logic signed [PW-1:0] pb_s2 [3];
	logic signed [PW-1:0] pc_s2 [3];
	logic signed [PW-1:0] pf_s2 [3];
	dot_t  opx [4];
	dot_t  opy [4];
	logic signed [2*HW-1:0] hh_s4 [4];
	logic signed [2*HW:0]   hl_s4 [4];
	logic signed [2*HW:0]   lh_s4 [4];
	logic [2*HW-1:0]        ll_s4 [4];
	wide_t xp_s5 [4];
	wide_t num_s6, den_s6;
	dot_t  thr_ext;
	wide_t denom, snum;

	assign thr_ext = $signed({{(DOTW-TW-FB){1'b0}}, thr, {FB{1'b0}}});
	assign denom   = xp_s5[0] - xp_s5[1];
	assign snum    = xp_s5[2] - xp_s5[3];

	always_comb begin
		ctx_d1 = '0;
		for (int k = 0; k < 3; k++) begin
			ctx_d1.p1[k] = pts_i[k];
			ctx_d1.p2[k] = pts_i[6+k];
			ctx_d1.d1[k] = sx_d(pts_i[3+k]) - sx_d(pts_i[k]);
			ctx_d1.d2[k] = sx_d(pts_i[9+k]) - sx_d(pts_i[6+k]);
			ctx_d1.r[k]  = sx_d(pts_i[k]) - sx_d(pts_i[6+k]);
		end
		ctx_d3   = ctx_s2;
		ctx_d3.a = DOTW'(pa_s2[0]) + DOTW'(pa_s2[1]) + DOTW'(pa_s2[2]);
		ctx_d3.e = DOTW'(pe_s2[0]) + DOTW'(pe_s2[1]) + DOTW'(pe_s2[2]);
		ctx_d3.b = DOTW'(pb_s2[0]) + DOTW'(pb_s2[1]) + DOTW'(pb_s2[2]);
		ctx_d3.c = DOTW'(pc_s2[0]) + DOTW'(pc_s2[1]) + DOTW'(pc_s2[2]);
		ctx_d3.f = DOTW'(pf_s2[0]) + DOTW'(pf_s2[1]) + DOTW'(pf_s2[2]);
		ctx_d4      = ctx_s3;
		ctx_d4.adeg = ($signed(ctx_s3.a) <= thr_ext);
		ctx_d4.edeg = ($signed(ctx_s3.e) <= thr_ext);
		opx[0] = ctx_s3.a;
		opy[0] = ctx_s3.e;
		opx[1] = ctx_s3.b;
		opy[1] = ctx_s3.b;
		opx[2] = ctx_s3.b;
		opy[2] = ctx_s3.f;
		opx[3] = ctx_s3.c;
		opy[3] = ctx_s3.e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// edge vectors
			ctx_s1 <= ctx_d1;
			// dot product terms
			ctx_s2 <= ctx_s1;
			for (int k = 0; k < 3; k++) begin
				pa_s2[k] <= $signed(ctx_s1.d1[k]) * $signed(ctx_s1.d1[k]);
				pe_s2[k] <= $signed(ctx_s1.d2[k]) * $signed(ctx_s1.d2[k]);
				pb_s2[k] <= $signed(ctx_s1.d1[k]) * $signed(ctx_s1.d2[k]);
				pc_s2[k] <= $signed(ctx_s1.d1[k]) * $signed(ctx_s1.r[k]);
				pf_s2[k] <= $signed(ctx_s1.d2[k]) * $signed(ctx_s1.r[k]);
			end
			ctx_s3 <= ctx_d3;
			// cross term partial products and degenerate checks
			ctx_s4 <= ctx_d4;
			for (int k = 0; k < 4; k++) begin
				hh_s4[k] <= $signed(opx[k][DOTW-1:HW]) * $signed(opy[k][DOTW-1:HW]);
				hl_s4[k] <= $signed(opx[k][DOTW-1:HW]) * $signed({1'b0, opy[k][HW-1:0]});
				lh_s4[k] <= $signed({1'b0, opx[k][HW-1:0]}) * $signed(opy[k][DOTW-1:HW]);
				ll_s4[k] <= opx[k][HW-1:0] * opy[k][HW-1:0];
			end
			// cross terms
			ctx_s5 <= ctx_s4;
			for (int k = 0; k < 4; k++) begin
				xp_s5[k] <= (wide_t'(hh_s4[k]) <<< (2 * HW))
					+ ((wide_t'(hl_s4[k]) + wide_t'(lh_s4[k])) <<< HW)
					+ wide_t'(ll_s4[k]);
			end
			// first quotient operands, parallel or degenerate case gives zero numerator
			ctx_s6 <= ctx_s5;
			den_s6 <= denom;
			num_s6 <= (ctx_s5.adeg || ctx_s5.edeg || denom == 0) ? '0 : snum;
		end
	end

	assign valid_o = vld_s6;
	assign num_o   = num_s6;
	assign den_o   = den_s6;
	assign ctx_o   = ctx_s6;

endmodule
`default_nettype wire

FILE: rtl/ssc_finish.sv
`default_nettype none
module ssc_finish import ssc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_i,
	input  wire ctx_t ctx_i,
	output logic      valid_o,
	output res_t      res_o
);
	localparam logic [SUMW-1:0] DMAX = SUMW'({DSTW{1'b1}});

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [MW-1:0]  m1_s1 [3];
	logic signed [MW-1:0]  m2_s1 [3];
	ctx_t ctx_s1, ctx_s2;
	logic signed [PTW-1:0] c1_s2 [3];
	logic signed [PTW-1:0] c2_s2 [3];
	logic signed [DFW-1:0] df_s3 [3];
	logic signed [SQW-1:0] sq_s4 [3];
	res_t res_s3, res_s4, res_s5, res_d5;
	logic [SUMW-1:0] sum, dist_sh;

	assign sum     = SUMW'(sq_s4[0]) + SUMW'(sq_s4[1]) + SUMW'(sq_s4[2]);
	assign dist_sh = sum >> FB;

	always_comb begin
		res_d5         = res_s4;
		res_d5.sq_dist = (dist_sh > DMAX) ? {DSTW{1'b1}} : dist_sh[DSTW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= valid_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_i;
			for (int k = 0; k < 3; k++) begin
				m1_s1[k] <= $signed(ctx_i.d1[k]) * $signed({1'b0, ctx_i.s});
				m2_s1[k] <= $signed(ctx_i.d2[k]) * $signed({1'b0, ctx_i.t});
			end
			ctx_s2 <= ctx_s1;
			for (int k = 0; k < 3; k++) begin
				c1_s2[k] <= PTW'(ctx_s1.p1[k]) + PTW'(m1_s1[k] >>> FB);
				c2_s2[k] <= PTW'(ctx_s1.p2[k]) + PTW'(m2_s1[k] >>> FB);
			end
			res_s3.sq_dist <= '0;
			res_s3.s       <= ctx_s2.s;
			res_s3.t       <= ctx_s2.t;
			for (int k = 0; k < 3; k++) begin
				df_s3[k]     <= DFW'(c1_s2[k]) - DFW'(c2_s2[k]);
				res_s3.n1[k] <= c1_s2[k][CW-1:0];
				res_s3.n2[k] <= c2_s2[k][CW-1:0];
			end
			res_s4 <= res_s3;
			for (int k = 0; k < 3; k++) begin
				sq_s4[k] <= df_s3[k] * df_s3[k];
			end
			res_s5 <= res_d5;
		end
	end

	assign valid_o = vld_s5;
	assign res_o   = res_s5;

endmodule
`default_nettype wire

FILE: rtl/segment_segment_closest_points.sv
// path: setup, s divider, t operand registers, t and r dividers, finish
// one pair per cycle unless stalled; two 17-stage quotient pipelines set depth
// a stalled response holds the whole pipeline, nothing is lost or repeated
// reset: arst_n clears all valid bits and sets degenerate_threshold to 0
`default_nettype none
module segment_segment_closest_points import ssc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ssc_cfg_if.sink   cfg,
	ssc_req_if.sink   req,
	ssc_rsp_if.source rsp
);
	logic [TW-1:0] thr_q;
	logic  en;
	pts_t  pts;
	logic  v_setup, v_div1, v_div2, v_fin;
	wide_t n_setup, d_setup;
	ctx_t  c_setup, c_div1, c_div2, c_fin;
	frac_t q1, q2, q3;
	logic  vld_s1, vld_s2;
	ctx_t  ctx_s1, ctx_s2;
	ctx_t  ctx_d1, ctx_d2;
	logic signed [BSW-1:0] bs_s1;
	wide_t tn_s2, td_s2, sn_s2, sd_s2;
	wide_t tnum, ebig;
	logic  general, tneg, tbig;
	res_t  res;

	assign en        = !rsp.valid || rsp.ready;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	assign pts = {req.second_end_z, req.second_end_y, req.second_end_x,
		req.second_start_z, req.second_start_y, req.second_start_x,
		req.first_end_z, req.first_end_y, req.first_end_x,
		req.first_start_z, req.first_start_y, req.first_start_x};

	ssc_setup u_setup (
		.clk(clk), .arst_n(arst_n), .en(en), .thr(thr_q),
		.valid_i(req.valid), .pts_i(pts),
		.valid_o(v_setup), .num_o(n_setup), .den_o(d_setup), .ctx_o(c_setup)
	);

	ssc_div u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_setup),
		.num_i(n_setup), .den_i(d_setup), .ctx_i(c_setup),
		.valid_o(v_div1), .quot_o(q1), .ctx_o(c_div1)
	);

	// t numerator from the first s
	assign tnum    = BSW'(bs_s1) + (sx_w(ctx_s1.f) <<< FB);
	assign ebig    = sx_w(ctx_s1.e) <<< FB;
	assign general = !ctx_s1.adeg && !ctx_s1.edeg;
	assign tneg    = general && (tnum < 0);
	assign tbig    = general && (tnum > ebig);

	always_comb begin
		ctx_d1       = c_div1;
		ctx_d1.s     = q1;
		ctx_d2       = ctx_s1;
		ctx_d2.sel_s = !ctx_s1.adeg && (ctx_s1.edeg || tneg || tbig);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= v_div1;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_d1;
			bs_s1  <= $signed(c_div1.b) * $signed({1'b0, q1});
			ctx_s2 <= ctx_d2;
			if (ctx_s1.adeg) begin
				tn_s2 <= ctx_s1.edeg ? '0 : sx_w(ctx_s1.f);
				td_s2 <= sx_w(ctx_s1.e);
			end else begin
				tn_s2 <= ctx_s1.edeg ? '0 : tnum;
				td_s2 <= ebig;
			end
			sn_s2 <= (ctx_s1.edeg || tneg) ? -sx_w(ctx_s1.c) :
				sx_w(ctx_s1.b) - sx_w(ctx_s1.c);
			sd_s2 <= sx_w(ctx_s1.a);
		end
	end

	ssc_div u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(vld_s2),
		.num_i(tn_s2), .den_i(td_s2), .ctx_i(ctx_s2),
		.valid_o(v_div2), .quot_o(q2), .ctx_o(c_div2)
	);

	ssc_div u_div_r (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(vld_s2),
		.num_i(sn_s2), .den_i(sd_s2), .ctx_i(ctx_s2),
		.valid_o(), .quot_o(q3), .ctx_o()
	);

	always_comb begin
		c_fin   = c_div2;
		c_fin.t = q2;
		c_fin.s = c_div2.sel_s ? q3 : c_div2.s;
	end
	assign v_fin = v_div2;

	ssc_finish u_finish (
		.clk(clk), .arst_n(arst_n), .en(en), .valid_i(v_fin), .ctx_i(c_fin),
		.valid_o(rsp.valid), .res_o(res)
	);

	assign rsp.squared_distance = res.sq_dist;
	assign rsp.param_first      = res.s;
	assign rsp.param_second     = res.t;
	assign rsp.near_first_x     = res.n1[0];
	assign rsp.near_first_y     = res.n1[1];
	assign rsp.near_first_z     = res.n1[2];
	assign rsp.near_second_x    = res.n2[0];
	assign rsp.near_second_y    = res.n2[1];
	assign rsp.near_second_z    = res.n2[2];

endmodule
`default_nettype wire

FILE: rtl/ssc_chk.sv
`default_nettype none
module ssc_chk import ssc_pkg::*; (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_ready,
	input wire logic            rsp_valid,
	input wire logic            rsp_ready,
	input wire logic [DSTW-1:0] rsp_dist,
	input wire frac_t           rsp_s,
	input wire frac_t           rsp_t
);
	a_rst_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !rsp_valid)
		else $error("response beat right after reset");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready == (!rsp_valid || rsp_ready))
		else $error("request ready does not follow output slot");

	a_param_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_s <= frac_t'(1 << FB)) && (rsp_t <= frac_t'(1 << FB)))
		else $error("segment parameter above one");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dist))
		else $error("stalled response beat changed");

endmodule

bind segment_segment_closest_points ssc_chk u_chk (
	.clk(clk), .arst_n(arst_n), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_dist(rsp.squared_distance),
	.rsp_s(rsp.param_first), .rsp_t(rsp.param_second)
);
`default_nettype wire
